@@ design/sisbw_pkg.sv @@
package sisbw_pkg;

  // Default storage and index sizes.
  localparam int unsigned CAPACITY   = 256;
  localparam int unsigned INDEX_BITS = 16;

  // Fixed field widths.
  localparam int unsigned VLEN_W   = 17;
  localparam int unsigned WEIGHT_W = 9;

  localparam logic [VLEN_W-1:0] VLEN_RESET = 17'h10000;

endpackage

@@ design/sorted_index_set_bit_write.sv @@
// Channel   Direction  Ports                                         Handshake
// request   in         bit_index_i, bit_value_i                      start, busy
// result    out        was_one_o, weight_o, store_full_o,            strobe_o
//                      index_out_of_range_o
// config    in         cfg_wdata_i                                   cfg_we_i
//
// An out-of-range request is answered in the cycle after it is accepted and never raises busy.
// Otherwise a binary search over the stored list costs a read state and a compare state
// per probe, at most log2(CAPACITY) + 1 probes, then a final read state closes the search and
// DECIDE decides. An insert or removal then moves every later entry through the list memory
// at one entry per cycle, and busy stays high until the result goes out.
// Reset clears the count and restores the vector length; the list needs no clearing.
// The result is shown for one cycle with strobe_o and the receiver cannot stall it;
// a new request may be started in the same cycle.
module sorted_index_set_bit_write #(
  parameter int unsigned CAPACITY   = sisbw_pkg::CAPACITY,
  parameter int unsigned INDEX_BITS = sisbw_pkg::INDEX_BITS
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  logic [INDEX_BITS-1:0]         bit_index_i,
  input  logic                          bit_value_i,
  input  logic                          cfg_we_i,
  input  logic [sisbw_pkg::VLEN_W-1:0]  cfg_wdata_i,
  output logic                          strobe_o,
  output logic                          was_one_o,
  output logic [sisbw_pkg::WEIGHT_W-1:0] weight_o,
  output logic                          store_full_o,
  output logic                          index_out_of_range_o
);

  localparam int unsigned AW    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CW    = $clog2(CAPACITY + 1);
  localparam int unsigned CMP_W = (INDEX_BITS > sisbw_pkg::VLEN_W) ? INDEX_BITS
                                                                    : sisbw_pkg::VLEN_W;

  typedef enum logic [2:0] {
    IDLE,
    SRCH_RD,
    SRCH_CMP,
    DECIDE,
    UP,
    UP_END,
    PUT,
    DN
  } state_e;

  state_e                         state_q;
  logic [sisbw_pkg::VLEN_W-1:0]   vlen_q;
  logic [CW-1:0]                  cnt_q;
  logic [CW-1:0]                  lo_q;
  logic [CW-1:0]                  hi_q;
  logic [CW-1:0]                  mid_q;
  logic [CW-1:0]                  ptr_q;
  logic                           hit_q;
  logic [INDEX_BITS-1:0]          idx_q;
  logic                           val_q;
  logic                           wr_pend_q;
  logic [AW-1:0]                  wr_addr_q;
  logic [INDEX_BITS-1:0]          rdata_q;
  logic                           strobe_q;
  logic                           was_q;
  logic [sisbw_pkg::WEIGHT_W-1:0] weight_q;
  logic                           full_q;
  logic                           oor_q;

  logic [INDEX_BITS-1:0]          mem [CAPACITY];

  logic [CW:0]                    mid_sum;
  logic [CW-1:0]                  mid;
  logic [AW-1:0]                  raddr;
  logic                           mem_we;
  logic [AW-1:0]                  waddr;
  logic [INDEX_BITS-1:0]          wdata;
  logic                           found;
  logic                           oor;

  assign mid_sum = {1'b0, lo_q} + {1'b0, hi_q};
  assign mid     = mid_sum[CW:1];
  assign found   = (lo_q < cnt_q) && hit_q;
  assign oor     = CMP_W'(bit_index_i) >= CMP_W'(vlen_q);

  always_comb begin
    case (state_q)
      UP, DN:  raddr = ptr_q[AW-1:0];
      default: raddr = mid[AW-1:0];
    endcase
  end

  // A shift step writes the entry read in the previous cycle; the final insert writes
  // the new index in its own cycle, after the last shifted entry has landed.
  assign mem_we = wr_pend_q || (state_q == PUT);
  assign waddr  = wr_pend_q ? wr_addr_q : lo_q[AW-1:0];
  assign wdata  = wr_pend_q ? rdata_q : idx_q;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[waddr] <= wdata;
    end
    rdata_q <= mem[raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= IDLE;
      vlen_q    <= sisbw_pkg::VLEN_RESET;
      cnt_q     <= '0;
      wr_pend_q <= 1'b0;
      strobe_q  <= 1'b0;
      lo_q      <= '0;
      hi_q      <= '0;
      mid_q     <= '0;
      ptr_q     <= '0;
      hit_q     <= 1'b0;
      idx_q     <= '0;
      val_q     <= 1'b0;
      wr_addr_q <= '0;
      was_q     <= 1'b0;
      weight_q  <= '0;
      full_q    <= 1'b0;
      oor_q     <= 1'b0;
    end else begin
      strobe_q  <= 1'b0;
      wr_pend_q <= 1'b0;
      if (cfg_we_i) begin
        vlen_q <= cfg_wdata_i;
      end
      case (state_q)
        IDLE: begin
          if (start) begin
            idx_q <= bit_index_i;
            val_q <= bit_value_i;
            lo_q  <= '0;
            hi_q  <= cnt_q;
            hit_q <= 1'b0;
            if (oor) begin
              strobe_q <= 1'b1;
              was_q    <= 1'b0;
              weight_q <= sisbw_pkg::WEIGHT_W'(cnt_q);
              full_q   <= 1'b0;
              oor_q    <= 1'b1;
            end else begin
              state_q <= SRCH_RD;
            end
          end
        end
        SRCH_RD: begin
          if (lo_q < hi_q) begin
            mid_q   <= mid;
            state_q <= SRCH_CMP;
          end else begin
            state_q <= DECIDE;
          end
        end
        SRCH_CMP: begin
          if (rdata_q < idx_q) begin
            lo_q <= mid_q + CW'(1);
          end else begin
            hi_q  <= mid_q;
            hit_q <= (rdata_q == idx_q);
          end
          state_q <= SRCH_RD;
        end
        DECIDE: begin
          was_q    <= found;
          full_q   <= 1'b0;
          oor_q    <= 1'b0;
          weight_q <= sisbw_pkg::WEIGHT_W'(cnt_q);
          if (val_q) begin
            if (found) begin
              strobe_q <= 1'b1;
              state_q  <= IDLE;
            end else if (cnt_q == CW'(CAPACITY)) begin
              full_q   <= 1'b1;
              strobe_q <= 1'b1;
              state_q  <= IDLE;
            end else if (lo_q == cnt_q) begin
              state_q <= PUT;
            end else begin
              ptr_q   <= cnt_q - CW'(1);
              state_q <= UP;
            end
          end else if (found) begin
            if (lo_q + CW'(1) < cnt_q) begin
              ptr_q   <= lo_q + CW'(1);
              state_q <= DN;
            end else begin
              cnt_q    <= cnt_q - CW'(1);
              weight_q <= sisbw_pkg::WEIGHT_W'(cnt_q - CW'(1));
              strobe_q <= 1'b1;
              state_q  <= IDLE;
            end
          end else begin
            strobe_q <= 1'b1;
            state_q  <= IDLE;
          end
        end
        UP: begin
          wr_pend_q <= 1'b1;
          wr_addr_q <= AW'(ptr_q + CW'(1));
          if (ptr_q == lo_q) begin
            state_q <= UP_END;
          end else begin
            ptr_q <= ptr_q - CW'(1);
          end
        end
        UP_END: begin
          state_q <= PUT;
        end
        PUT: begin
          cnt_q    <= cnt_q + CW'(1);
          weight_q <= sisbw_pkg::WEIGHT_W'(cnt_q + CW'(1));
          strobe_q <= 1'b1;
          state_q  <= IDLE;
        end
        DN: begin
          wr_pend_q <= 1'b1;
          wr_addr_q <= AW'(ptr_q - CW'(1));
          if (ptr_q == cnt_q - CW'(1)) begin
            // The last moved entry is written in the same cycle as the result goes out.
            cnt_q    <= cnt_q - CW'(1);
            weight_q <= sisbw_pkg::WEIGHT_W'(cnt_q - CW'(1));
            strobe_q <= 1'b1;
            state_q  <= IDLE;
          end else begin
            ptr_q <= ptr_q + CW'(1);
          end
        end
        default: begin
          state_q <= IDLE;
        end
      endcase
    end
  end

  assign busy                 = (state_q != IDLE);
  assign strobe_o             = strobe_q;
  assign was_one_o            = was_q;
  assign weight_o             = weight_q;
  assign store_full_o         = full_q;
  assign index_out_of_range_o = oor_q;

  // A result always comes out with the block ready for the next request.
  a_strobe_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o |-> !busy)
    else $error("result shown while a request is still in progress");

  // An accepted request either keeps the block busy or answers at once.
  a_start_progress: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> (busy || strobe_o))
    else $error("accepted request neither started nor answered");

  // A refused or rejected write reports no earlier one and only one reason.
  a_flags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (strobe_o && (store_full_o || index_out_of_range_o)) |->
      (!was_one_o && !(store_full_o && index_out_of_range_o)))
    else $error("inconsistent result flags");

  // The stored count never exceeds the list size.
  a_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(CAPACITY))
    else $error("stored count above capacity");

  // A pending shift write never collides with the insert of the new index.
  a_port: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_pend_q |-> (state_q != PUT))
    else $error("two writes to the list memory in one cycle");

endmodule

@@ test/tb_top.sv @@
module tb_top;

  localparam int unsigned CAPACITY   = sisbw_pkg::CAPACITY;
  localparam int unsigned INDEX_BITS = sisbw_pkg::INDEX_BITS;
  localparam int unsigned VLEN_W     = sisbw_pkg::VLEN_W;
  localparam int unsigned WEIGHT_W   = sisbw_pkg::WEIGHT_W;
  localparam logic [VLEN_W-1:0] VLEN_RESET = sisbw_pkg::VLEN_RESET;

  localparam int unsigned IDLE_PCT       = 22;
  localparam int unsigned SETTLE_CYCLES  = 4;
  localparam int unsigned TAIL_CYCLES    = 300;
  localparam int unsigned WATCHDOG_LIMIT = 4000;
  localparam int unsigned MAX_REPORTS    = 10;

  typedef enum logic [1:0] {
    STEP_WRITE,
    STEP_CONFIG,
    STEP_SETTLE
  } step_kind_e;

  typedef struct {
    step_kind_e              kind;
    logic [INDEX_BITS-1:0]   index;
    logic                    value;
    logic [VLEN_W-1:0]       length;
  } bench_step_t;

  typedef struct {
    logic                was_one;
    logic [WEIGHT_W-1:0] weight;
    logic                store_full;
    logic                out_of_range;
  } bit_write_outcome_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic                  req_start = 1'b0;
  logic [INDEX_BITS-1:0] req_index = '0;
  logic                  req_value = 1'b0;
  logic                  cfg_we = 1'b0;
  logic [VLEN_W-1:0]     cfg_wdata = VLEN_RESET;

  logic                  busy;
  logic                  strobe_o;
  logic                  was_one_o;
  logic [WEIGHT_W-1:0]   weight_o;
  logic                  store_full_o;
  logic                  index_out_of_range_o;

  bench_step_t           pending_steps[$];
  bit_write_outcome_t    write_outcomes[$];
  logic [INDEX_BITS-1:0] one_positions[$];
  logic [VLEN_W-1:0]     length_shadow = VLEN_RESET;
  logic [INDEX_BITS-1:0] hot_indices[$];

  int unsigned mismatches = 0;
  int unsigned requests_sent = 0;
  int unsigned settle_count = 0;
  int unsigned quiet_cycles = 0;

  sorted_index_set_bit_write u_top (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .start                (req_start),
    .busy                 (busy),
    .bit_index_i          (req_index),
    .bit_value_i          (req_value),
    .cfg_we_i             (cfg_we),
    .cfg_wdata_i          (cfg_wdata),
    .strobe_o             (strobe_o),
    .was_one_o            (was_one_o),
    .weight_o             (weight_o),
    .store_full_o         (store_full_o),
    .index_out_of_range_o (index_out_of_range_o)
  );

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  // Applies one accepted request to the shadow list and records what the block must return.
  function automatic void apply_bit_write(input logic [INDEX_BITS-1:0] idx, input logic val);
    bit_write_outcome_t res;
    int slot;
    res.was_one = 1'b0;
    res.store_full = 1'b0;
    res.out_of_range = 1'b0;
    if (idx >= length_shadow) begin
      res.out_of_range = 1'b1;
    end else begin
      slot = 0;
      while (slot < one_positions.size() && one_positions[slot] < idx) slot++;
      res.was_one = (slot < one_positions.size()) && (one_positions[slot] == idx);
      if (val && !res.was_one) begin
        if (one_positions.size() >= CAPACITY) res.store_full = 1'b1;
        else one_positions.insert(slot, idx);
      end else if (!val && res.was_one) begin
        one_positions.delete(slot);
      end
    end
    res.weight = WEIGHT_W'(one_positions.size());
    write_outcomes.push_back(res);
  endfunction

  task automatic queue_write(input logic [INDEX_BITS-1:0] idx, input logic val);
    bench_step_t s;
    s.kind = STEP_WRITE;
    s.index = idx;
    s.value = val;
    s.length = '0;
    pending_steps.push_back(s);
  endtask

  // The length register is only changed once the block has gone quiet.
  task automatic queue_length(input logic [VLEN_W-1:0] len);
    bench_step_t s;
    s.kind = STEP_SETTLE;
    s.index = '0;
    s.value = 1'b0;
    s.length = '0;
    pending_steps.push_back(s);
    s.kind = STEP_CONFIG;
    s.length = len;
    pending_steps.push_back(s);
  endtask

  // Most requests hit a small set of hot indices so that inserts and removals find each
  // other; the rest is noise over the whole index range.
  task automatic queue_phase(input logic [VLEN_W-1:0] len, input int unsigned hot_count,
                             input int unsigned insert_pct, input int unsigned count);
    int unsigned span;
    logic [INDEX_BITS-1:0] idx;
    queue_length(len);
    span = (len == 0 || len > 65536) ? 65536 : len;
    if (hot_count > 0) begin
      hot_indices.delete();
      repeat (hot_count) hot_indices.push_back(INDEX_BITS'($urandom_range(span - 1, 0)));
    end
    repeat (count) begin
      if ($urandom_range(99) < 10) begin
        queue_write(INDEX_BITS'($urandom), 1'($urandom));
      end else begin
        idx = hot_indices[$urandom_range(hot_indices.size() - 1, 0)];
        queue_write(idx, $urandom_range(99) < insert_pct);
      end
    end
  endtask

  // Driver: presents requests and register writes taken from the pending queue.
  always @(posedge clk_i) begin
    logic nx_start;
    logic nx_we;
    bit quiet;
    nx_start = req_start;
    nx_we = 1'b0;
    if (rst_ni) begin
      if (req_start && !busy) begin
        apply_bit_write(req_index, req_value);
        requests_sent++;
        nx_start = 1'b0;
      end
      quiet = (requests_sent >= 700) && (requests_sent < 1000);
      if (!nx_start && pending_steps.size() > 0) begin
        case (pending_steps[0].kind)
          STEP_WRITE: begin
            if (quiet || $urandom_range(99) >= IDLE_PCT) begin
              nx_start = 1'b1;
              req_index <= pending_steps[0].index;
              req_value <= pending_steps[0].value;
              void'(pending_steps.pop_front());
            end
          end
          STEP_CONFIG: begin
            nx_we = 1'b1;
            cfg_wdata <= pending_steps[0].length;
            length_shadow = pending_steps[0].length;
            void'(pending_steps.pop_front());
          end
          default: begin
            if (write_outcomes.size() == 0 && !busy) begin
              settle_count++;
              if (settle_count >= SETTLE_CYCLES) begin
                settle_count = 0;
                void'(pending_steps.pop_front());
              end
            end else begin
              settle_count = 0;
            end
          end
        endcase
      end
    end
    req_start <= nx_start;
    cfg_we <= nx_we;
  end

  // Monitor: every strobed result is matched against the oldest expectation.
  always @(posedge clk_i) begin
    bit_write_outcome_t want;
    if (rst_ni && strobe_o) begin
      if (write_outcomes.size() == 0) begin
        if (mismatches < MAX_REPORTS)
          $display("unexpected result: was_one=%0b weight=%0d full=%0b oor=%0b",
                   was_one_o, weight_o, store_full_o, index_out_of_range_o);
        mismatches++;
      end else begin
        want = write_outcomes.pop_front();
        if (was_one_o !== want.was_one || weight_o !== want.weight ||
            store_full_o !== want.store_full || index_out_of_range_o !== want.out_of_range)
        begin
          if (mismatches < MAX_REPORTS)
            $display("mismatch: expected was_one=%0b weight=%0d full=%0b oor=%0b, %s%0b %0d %0b %0b",
                     want.was_one, want.weight, want.store_full, want.out_of_range,
                     "got ", was_one_o, weight_o, store_full_o, index_out_of_range_o);
          mismatches++;
        end
      end
    end
  end

  // Watchdog on cycles in which no request, result or register write is accepted.
  always @(posedge clk_i) begin
    if (!rst_ni || (req_start && !busy) || strobe_o || cfg_we) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("simulation failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    // Short directed run at the reset length.
    queue_write(16'd0, 1'b0);
    queue_write(16'd0, 1'b1);
    queue_write(16'd0, 1'b1);
    queue_write(16'hFFFF, 1'b1);
    queue_write(16'h8000, 1'b1);
    queue_write(16'd1, 1'b1);
    queue_write(16'hFFFF, 1'b0);
    queue_write(16'hFFFF, 1'b0);
    queue_write(16'd0, 1'b0);
    queue_write(16'h7FFF, 1'b1);
    // A zero length rejects everything.
    queue_length(17'd0);
    queue_write(16'd0, 1'b1);
    queue_write(16'hFFFF, 1'b0);
    queue_length(17'd1);
    queue_write(16'd0, 1'b1);
    queue_write(16'd1, 1'b1);
    queue_write(16'd0, 1'b0);
    // Lengths above the index range accept every index.
    queue_length(17'h1FFFF);
    queue_write(16'hFFFF, 1'b1);
    queue_write(16'hFFFF, 1'b1);
    queue_length(17'hFFFF);
    queue_write(16'hFFFF, 1'b1);
    queue_write(16'hFFFE, 1'b1);
    queue_write(16'hFFFE, 1'b0);

    queue_phase(17'h10000, 16, 50, 200);
    queue_phase(VLEN_W'($urandom_range(65536, 1)), 64, 50, 200);
    // Enough distinct hot indices to fill the list and then refuse inserts.
    queue_phase(17'h1FFFF, 300, 90, 450);
    queue_phase(17'hFFFF, 0, 40, 250);
    queue_phase(17'd1, 8, 50, 100);
    queue_phase(17'd0, 8, 50, 50);
    queue_phase(VLEN_W'($urandom_range(300, 2)), 40, 55, 200);
    queue_phase(17'h10000, 100, 60, 150);

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (pending_steps.size() != 0 || req_start || write_outcomes.size() != 0)
      @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
design/sisbw_pkg.sv
design/sorted_index_set_bit_write.sv
test/tb_top.sv
